// ----- hw/rtl/sssp_pkg.sv -----
`default_nettype none

package sssp_pkg;

    // Field widths fixed by the item format
    localparam int IDX_W    = 6;
    localparam int WT_IN_W  = 16;
    localparam int LEN_W    = 22;
    localparam int CFG_W    = 7;

    // Register reset value
    localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

    // Item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    // One input beat
    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   row_index;
        logic [IDX_W-1:0]   col_index;
        logic [WT_IN_W-1:0] edge_weight;
        logic               no_edge;
        logic [IDX_W-1:0]   source_vertex;
    } t_in_beat;

    // One result beat
    typedef struct packed {
        logic [IDX_W-1:0] vertex_id;
        logic [LEN_W-1:0] path_length;
        logic             reachable;
        logic             last;
    } t_out_beat;

endpackage

`default_nettype wire

// ----- hw/rtl/sssp_core.sv -----
`default_nettype none

module sssp_core #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16,
    parameter int CW           = $clog2(MAX_VERTICES + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire sssp_pkg::t_in_beat  i_in,
    input  wire  [CW-1:0]            i_count,
    output logic                     o_res_valid,
    input  wire                      i_res_stall,
    output sssp_pkg::t_out_beat      o_res
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int DW    = WEIGHT_BITS + VW;
    localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = sssp_pkg::IDX_W;
    localparam int LW    = sssp_pkg::LEN_W;
    localparam logic [AW-1:0] MAXA = AW'(MAX_VERTICES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PICK   = 3'd1;
    localparam logic [2:0] S_RELAX  = 3'd2;
    localparam logic [2:0] S_OUT_RD = 3'd3;
    localparam logic [2:0] S_OUT_WR = 3'd4;

    // Control registers
    logic [2:0]              r_state,   n_state;
    logic [CW-1:0]           r_idx,     n_idx;
    logic                    r_pv,      n_pv;
    logic [VW-1:0]           r_pidx,    n_pidx;
    logic                    r_found,   n_found;
    logic [VW-1:0]           r_best,    n_best;
    logic [DW-1:0]           r_best_d,  n_best_d;
    logic [VW-1:0]           r_u,       n_u;
    logic [DW-1:0]           r_du,      n_du;
    logic [CW-1:0]           r_round,   n_round;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [MAX_VERTICES-1:0] r_finite,  n_finite;

    // Memories
    logic [DW-1:0]          dist_mem [MAX_VERTICES];
    logic [DW-1:0]          r_dist_rd;
    logic [WEIGHT_BITS:0]   wt_mem [CELLS];
    logic [WEIGHT_BITS:0]   r_w_rd;

    logic                   dist_we;
    logic [VW-1:0]          dist_waddr;
    logic [DW-1:0]          dist_wdata;
    logic                   wt_we;
    logic [AW-1:0]          wt_waddr;
    logic [AW-1:0]          wt_raddr;
    logic [WEIGHT_BITS:0]   wt_wdata;

    // Input decode
    logic                   accept;
    logic [VW+IW-1:0]       row_ext, col_ext, src_ext;
    logic [WEIGHT_BITS+sssp_pkg::WT_IN_W-1:0] wt_ext;
    logic                   row_ok, col_ok, src_ok;
    logic                   sweep_end;
    logic [DW-1:0]          cand;
    logic                   pick_hit, relax_hit;
    logic                   last_v;
    logic [CW+IW-1:0]       vid_ext;
    logic [DW+LW-1:0]       len_ext;

    assign accept  = i_in_valid && !o_in_stall;
    assign row_ext = {VW'(0), i_in.row_index};
    assign col_ext = {VW'(0), i_in.col_index};
    assign src_ext = {VW'(0), i_in.source_vertex};
    assign wt_ext  = {WEIGHT_BITS'(0), i_in.edge_weight};
    assign row_ok  = ({9'd0, i_in.row_index} < (IW + 9)'(MAX_VERTICES));
    assign col_ok  = ({9'd0, i_in.col_index} < (IW + 9)'(MAX_VERTICES));
    assign src_ok  = ({CW'(0), i_in.source_vertex} < {IW'(0), i_count});

    // Shared sweep unit: one vertex per cycle, compare in the cycle after the read
    assign sweep_end = (r_idx == i_count) && !r_pv;
    assign cand      = r_du + DW'(r_w_rd[WEIGHT_BITS-1:0]);
    assign pick_hit  = r_pv && !r_visited[r_pidx] && r_finite[r_pidx] &&
                       (!r_found || (r_dist_rd < r_best_d));
    assign relax_hit = r_pv && !r_visited[r_pidx] && r_w_rd[WEIGHT_BITS] &&
                       (!r_finite[r_pidx] || (cand < r_dist_rd));
    assign last_v    = ((CW+1)'(r_idx) + (CW+1)'(1)) == (CW+1)'(i_count);

    // Memory port control
    assign wt_we      = accept && (i_in.mode == sssp_pkg::MODE_LOAD) && row_ok && col_ok;
    assign wt_waddr   = AW'(row_ext[VW-1:0]) * MAXA + AW'(col_ext[VW-1:0]);
    assign wt_wdata   = {!i_in.no_edge, wt_ext[WEIGHT_BITS-1:0]};
    assign wt_raddr   = AW'(r_u) * MAXA + AW'(r_idx[VW-1:0]);

    always_comb begin
        dist_we    = 1'b0;
        dist_waddr = r_pidx;
        dist_wdata = cand;
        if (r_state == S_IDLE) begin
            dist_we    = accept && (i_in.mode == sssp_pkg::MODE_RUN) && src_ok;
            dist_waddr = src_ext[VW-1:0];
            dist_wdata = '0;
        end else if (r_state == S_RELAX) begin
            dist_we    = relax_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        r_dist_rd <= dist_mem[r_idx[VW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wt_we) begin
            wt_mem[wt_waddr] <= wt_wdata;
        end
        r_w_rd <= wt_mem[wt_raddr];
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pv      = r_pv;
        n_pidx    = r_pidx;
        n_found   = r_found;
        n_best    = r_best;
        n_best_d  = r_best_d;
        n_u       = r_u;
        n_du      = r_du;
        n_round   = r_round;
        n_visited = r_visited;
        n_finite  = r_finite;

        // advance the sweep index and the compare stage
        if ((r_state == S_PICK) || (r_state == S_RELAX)) begin
            if (r_idx != i_count) begin
                n_idx  = r_idx + CW'(1);
                n_pv   = 1'b1;
                n_pidx = r_idx[VW-1:0];
            end else begin
                n_pv   = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept && (i_in.mode == sssp_pkg::MODE_RUN) && src_ok) begin
                    n_visited = '0;
                    n_finite  = '0;
                    n_finite[src_ext[VW-1:0]] = 1'b1;
                    n_round   = '0;
                    n_idx     = '0;
                    n_pv      = 1'b0;
                    n_found   = 1'b0;
                    n_state   = (i_count == CW'(1)) ? S_OUT_RD : S_PICK;
                end
            end
            S_PICK: begin
                if (pick_hit) begin
                    n_found  = 1'b1;
                    n_best   = r_pidx;
                    n_best_d = r_dist_rd;
                end
                if (sweep_end) begin
                    n_idx = '0;
                    n_pv  = 1'b0;
                    if (!r_found) begin
                        n_state = S_OUT_RD;
                    end else begin
                        n_visited[r_best] = 1'b1;
                        n_u     = r_best;
                        n_du    = r_best_d;
                        n_state = S_RELAX;
                    end
                end
            end
            S_RELAX: begin
                if (relax_hit) begin
                    n_finite[r_pidx] = 1'b1;
                end
                if (sweep_end) begin
                    n_idx   = '0;
                    n_pv    = 1'b0;
                    n_found = 1'b0;
                    n_round = r_round + CW'(1);
                    if (((CW+1)'(r_round) + (CW+1)'(2)) < (CW+1)'(i_count)) begin
                        n_state = S_PICK;
                    end else begin
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_WR;
            end
            S_OUT_WR: begin
                if (!i_res_stall) begin
                    if (last_v) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_pv      <= 1'b0;
            r_found   <= 1'b0;
            r_round   <= '0;
            r_visited <= '0;
            r_finite  <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_pv      <= n_pv;
            r_found   <= n_found;
            r_round   <= n_round;
            r_visited <= n_visited;
            r_finite  <= n_finite;
        end
    end

    // Hold payload of the sweep
    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_best   <= n_best;
        r_best_d <= n_best_d;
        r_u      <= n_u;
        r_du     <= n_du;
    end

    // Result beat
    assign vid_ext = {IW'(0), r_idx};
    assign len_ext = {LW'(0), r_dist_rd};

    always_comb begin
        o_res.vertex_id   = vid_ext[IW-1:0];
        o_res.reachable   = r_finite[r_idx[VW-1:0]];
        o_res.path_length = r_finite[r_idx[VW-1:0]] ? len_ext[LW-1:0] : '0;
        o_res.last        = last_v;
    end

    assign o_res_valid = (r_state == S_OUT_WR);
    assign o_in_stall  = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- hw/rtl/single_source_shortest_path_top.sv -----
// Channel   Direction  Beat type             Handshake
// in        input      sssp_pkg::t_in_beat   i_in_valid / o_in_stall
// out       output     sssp_pkg::t_out_beat  o_out_valid / i_out_stall
// cfg       input      7-bit vertex count    i_cfg_we / i_cfg_wdata
//
// Load beats leave the input ready for the next beat. A run over n vertices
// has at most n-1 rounds; each round sweeps the single distance memory port
// once for the minimum and once for relaxation.
// Reset is synchronous, active low; the matrix memory is not cleared.
// The input stalls for the whole run; the output register frees the core.
`default_nettype none

module single_source_shortest_path_top #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire sssp_pkg::t_in_beat           i_in,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output sssp_pkg::t_out_beat               o_out,
    input  wire                               i_cfg_we,
    input  wire  [sssp_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = CW + sssp_pkg::CFG_W + 1;

    logic [sssp_pkg::CFG_W-1:0] r_vcount;
    logic [CMPW-1:0]            vcount_ext;
    logic [CMPW-1:0]            count_sel;
    logic [CW-1:0]              count;

    logic                       res_valid;
    logic                       res_stall;
    sssp_pkg::t_out_beat        res;

    logic                       r_out_valid, n_out_valid;
    sssp_pkg::t_out_beat        r_out;

    // Hold the vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= sssp_pkg::VCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    // Clamp the count into 1 .. MAX_VERTICES
    assign vcount_ext = {(CW + 1)'(0), r_vcount};

    always_comb begin
        if (vcount_ext == '0) begin
            count_sel = CMPW'(1);
        end else if (vcount_ext > CMPW'(MAX_VERTICES)) begin
            count_sel = CMPW'(MAX_VERTICES);
        end else begin
            count_sel = vcount_ext;
        end
    end

    assign count = count_sel[CW-1:0];

    sssp_core #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .CW           (CW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_count     (count),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_res       (res)
    );

    // Output register: load a new beat when it is empty or the held one leaves
    assign res_stall = r_out_valid && i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid && !res_stall) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && !res_stall) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/sssp_check.sv -----
`default_nettype none

module sssp_check (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_in_valid,
    input wire                        o_in_stall,
    input wire sssp_pkg::t_in_beat    i_in,
    input wire                        o_out_valid,
    input wire                        i_out_stall,
    input wire sssp_pkg::t_out_beat   o_out
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // Input stays blocked while a run still has results to deliver
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |-> o_in_stall)
        else $error("input open before the last result");

    // Load beat leaves the block ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.mode == sssp_pkg::MODE_LOAD) |=> !o_in_stall)
        else $error("load beat made the block busy");

    // Unreachable vertex reports zero length
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.reachable |-> (o_out.path_length == '0))
        else $error("unreachable vertex with nonzero length");

endmodule

bind single_source_shortest_path_top sssp_check u_sssp_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

// ----- test/single_source_shortest_path_top_tb.sv -----
`default_nettype none

module single_source_shortest_path_top_tb;
    import sssp_pkg::*;

    localparam int MAX_V       = 64;
    localparam int SMALL_V     = 5;
    localparam int GUARD_V     = 63;
    localparam int SETTLE      = 16;
    localparam int HOLD_LONG   = 400;
    localparam int PHASE_ITEMS = 4;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_e;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_e;

    typedef struct {
        row_kind_e        kind;
        logic [CFG_W-1:0] cfg_val;
        t_in_beat         beat;
        row_check_e       chk;
        t_out_beat        res;
    } directed_row_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_beat         i_in;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_beat        o_out;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    // Predictor copy of the matrix and the vertex count register
    logic [WT_IN_W-1:0] weight_mem [MAX_V*MAX_V];
    bit                 edge_mem   [MAX_V*MAX_V];
    logic [CFG_W-1:0]   vertex_count;
    t_out_beat          expected_paths [$];

    int send_gap_pct   = 0;
    int out_stall_pct  = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int n_loads        = 0;
    int n_runs         = 0;
    int n_ignored      = 0;
    int n_checked      = 0;
    int n_cfg          = 0;

    single_source_shortest_path_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                     cycle_count, expected_paths.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int active_vertices(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_V)
            return MAX_V;
        return int'(v);
    endfunction

    // Dijkstra over the first n vertices; queue one distance beat per vertex
    function automatic void shortest_paths_predict(int src, int n);
        longint unsigned path_d [MAX_V];
        bit              reach  [MAX_V];
        bit              done   [MAX_V];
        longint unsigned cand;
        int              pick;
        int              entry;
        t_out_beat       r;
        for (int i = 0; i < MAX_V; i++) begin
            path_d[i] = 0;
            reach[i]  = 1'b0;
            done[i]   = 1'b0;
        end
        reach[src] = 1'b1;
        for (int rnd = 0; rnd + 1 < n; rnd++) begin
            pick = n;
            for (int i = 0; i < n; i++) begin
                if (!done[i] && reach[i] && (pick == n || path_d[i] < path_d[pick]))
                    pick = i;
            end
            if (pick == n)
                break;
            done[pick] = 1'b1;
            // Relax every unvisited neighbor of the picked vertex
            for (int v = 0; v < n; v++) begin
                entry = pick * MAX_V + v;
                if (!done[v] && edge_mem[entry]) begin
                    cand = path_d[pick] + longint'(weight_mem[entry]);
                    if (!reach[v] || cand < path_d[v]) begin
                        path_d[v] = cand;
                        reach[v]  = 1'b1;
                    end
                end
            end
        end
        for (int v = 0; v < n; v++) begin
            r             = '0;
            r.vertex_id   = IDX_W'(v);
            r.path_length = reach[v] ? LEN_W'(path_d[v]) : '0;
            r.reachable   = reach[v];
            r.last        = (v + 1 == n);
            expected_paths.push_back(r);
        end
    endfunction

    // Update the predictor for one accepted beat
    function automatic void apply_beat(t_in_beat b, bit predict_results);
        int n;
        int entry;
        n = active_vertices(vertex_count);
        if (b.mode == MODE_LOAD) begin
            entry             = int'(b.row_index) * MAX_V + int'(b.col_index);
            weight_mem[entry] = b.edge_weight;
            edge_mem[entry]   = !b.no_edge;
            n_loads++;
        end else begin
            n_runs++;
            if (int'(b.source_vertex) >= n)
                n_ignored++;
            else if (predict_results)
                shortest_paths_predict(int'(b.source_vertex), n);
        end
    endfunction

    function automatic logic [WT_IN_W-1:0] rand_weight();
        case ($urandom_range(3))
            0: return '1;
            1: return '0;
            2: return WT_IN_W'($urandom_range(255));
            default: return WT_IN_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_in_beat make_load(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                           logic [WT_IN_W-1:0] wt, logic none);
        t_in_beat b;
        b.mode          = MODE_LOAD;
        b.row_index     = row;
        b.col_index     = col;
        b.edge_weight   = wt;
        b.no_edge       = none;
        b.source_vertex = IDX_W'($urandom_range(63));
        return b;
    endfunction

    function automatic t_in_beat make_run(logic [IDX_W-1:0] src);
        t_in_beat b;
        b.mode          = MODE_RUN;
        b.row_index     = IDX_W'($urandom_range(63));
        b.col_index     = IDX_W'($urandom_range(63));
        b.edge_weight   = WT_IN_W'($urandom_range(65535));
        b.no_edge       = $urandom_range(1);
        b.source_vertex = src;
        return b;
    endfunction

    function automatic directed_row_t cfg_row(logic [CFG_W-1:0] v);
        directed_row_t d;
        d.kind    = ROW_CFG;
        d.cfg_val = v;
        d.beat    = '0;
        d.chk     = CHK_NONE;
        d.res     = '0;
        return d;
    endfunction

    function automatic directed_row_t beat_row(t_in_beat b, row_check_e chk, t_out_beat res);
        directed_row_t d;
        d.kind    = ROW_BEAT;
        d.cfg_val = '0;
        d.beat    = b;
        d.chk     = chk;
        d.res     = res;
        return d;
    endfunction

    // A graph of one vertex: the source alone, at distance zero
    function automatic t_out_beat lone_vertex_result();
        t_out_beat r;
        r           = '0;
        r.reachable = 1'b1;
        r.last      = 1'b1;
        return r;
    endfunction

    function automatic void set_idle(int mode);
        case (mode)
            0: begin send_gap_pct = 0;  out_stall_pct = 0;  end
            1: begin send_gap_pct = 54; out_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  out_stall_pct = 54; end
            default: begin send_gap_pct = 14; out_stall_pct = 14; end
        endcase
    endfunction

    function automatic void check_field(string name, int vid, logic [LEN_W-1:0] want,
                                        logic [LEN_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch at vertex %0d, expected %0d, got %0d",
                     $time, name, vid, want, got);
        end
    endfunction

    // Offer one beat with random gaps; hold it until accepted
    task automatic push_beat(t_in_beat b, bit predict_results);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in       = b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        apply_beat(b, predict_results);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected beat is back
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (expected_paths.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(logic [CFG_W-1:0] v);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we     = 1'b0;
        vertex_count = v;
        n_cfg++;
    endtask

    // Output side: random stalls, plus a long hold when asked
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left   = hold_left - 1;
            end else begin
                i_out_stall = ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : check_out
        t_out_beat want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_paths.size() == 0) begin
                mismatch_count++;
                $display("%0t: expected no result beat, got vertex %0d length %0d",
                         $time, o_out.vertex_id, o_out.path_length);
            end else begin
                want = expected_paths.pop_front();
                n_checked++;
                check_field("vertex_id", want.vertex_id, LEN_W'(want.vertex_id),
                            LEN_W'(o_out.vertex_id));
                check_field("path_length", want.vertex_id, want.path_length,
                            o_out.path_length);
                check_field("reachable", want.vertex_id, LEN_W'(want.reachable),
                            LEN_W'(o_out.reachable));
                check_field("last", want.vertex_id, LEN_W'(want.last), LEN_W'(o_out.last));
            end
        end
    end

    initial begin : stimulus
        directed_row_t    directed [$];
        int               vc_plan [8];
        int               n_eff;
        int               issued;
        int               n_pre;
        bit               big;
        bit               gone;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] src;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        vertex_count = VCOUNT_RESET;
        for (int i = 0; i < MAX_V * MAX_V; i++) begin
            weight_mem[i] = '0;
            edge_mem[i]   = 1'b0;
        end

        // Directed rows: clamped counts, tiny graphs, weight and index extremes
        directed.push_back(cfg_row(7'd0));
        directed.push_back(beat_row(make_run(6'd0), CHK_ONE, lone_vertex_result()));
        directed.push_back(beat_row(make_run(6'd63), CHK_NONE, '0));
        directed.push_back(beat_row(make_run(6'd1), CHK_NONE, '0));
        directed.push_back(cfg_row(7'd2));
        directed.push_back(beat_row(make_load(6'd0, 6'd0, 16'hFFFF, 1'b0), CHK_MODEL, '0));
        directed.push_back(beat_row(make_load(6'd0, 6'd1, 16'hFFFF, 1'b0), CHK_MODEL, '0));
        directed.push_back(beat_row(make_load(6'd1, 6'd0, 16'hFFFF, 1'b1), CHK_MODEL, '0));
        directed.push_back(beat_row(make_load(6'd1, 6'd1, 16'h0000, 1'b0), CHK_MODEL, '0));
        directed.push_back(beat_row(make_run(6'd0), CHK_MODEL, '0));
        directed.push_back(beat_row(make_run(6'd1), CHK_MODEL, '0));
        directed.push_back(beat_row(make_run(6'd2), CHK_NONE, '0));
        directed.push_back(beat_row(make_load(6'd0, 6'd1, 16'h0000, 1'b0), CHK_MODEL, '0));
        directed.push_back(beat_row(make_load(6'd1, 6'd0, 16'h0001, 1'b0), CHK_MODEL, '0));
        directed.push_back(beat_row(make_run(6'd1), CHK_MODEL, '0));
        directed.push_back(beat_row(make_run(6'd0), CHK_MODEL, '0));
        directed.push_back(beat_row(make_load(6'd63, 6'd63, 16'hFFFF, 1'b0), CHK_MODEL, '0));
        directed.push_back(beat_row(make_load(6'd63, 6'd0, 16'h0000, 1'b1), CHK_MODEL, '0));
        directed.push_back(beat_row(make_load(6'd0, 6'd63, 16'h8000, 1'b0), CHK_MODEL, '0));
        directed.push_back(cfg_row(7'd1));
        directed.push_back(beat_row(make_run(6'd0), CHK_ONE, lone_vertex_result()));

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (SETTLE) @(negedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].kind == ROW_CFG) begin
                write_vertex_count(directed[k].cfg_val);
            end else begin
                if (directed[k].chk == CHK_ONE)
                    expected_paths.push_back(directed[k].res);
                push_beat(directed[k].beat, directed[k].chk == CHK_MODEL);
            end
        end

        // Write a small dense block with chains, and a guard row whose only edge is to itself
        set_idle(1);
        for (int r = 0; r < SMALL_V; r++) begin
            for (int c = 0; c < SMALL_V; c++) begin
                gone = !((c == r + 1 && $urandom_range(3) != 0) || $urandom_range(3) == 0);
                push_beat(make_load(IDX_W'(r), IDX_W'(c), rand_weight(), gone), 1'b1);
            end
        end
        for (int c = 0; c < MAX_V; c++)
            push_beat(make_load(IDX_W'(GUARD_V), IDX_W'(c), rand_weight(), c != GUARD_V),
                      1'b1);

        // Random phases: a few loads then a run, over several vertex counts.
        // Small counts run inside the dense block; full counts run from the
        // guard vertex, so only the guard row is ever swept.
        vc_plan = '{5, 127, 3, 65, 4, 0, 2, 64};
        for (int phase = 0; phase < 8; phase++) begin
            set_idle(phase % 4);
            write_vertex_count(CFG_W'(vc_plan[phase]));
            n_eff = active_vertices(vertex_count);
            big   = (n_eff > SMALL_V);
            if (phase == 3)
                hold_left = HOLD_LONG;
            issued = 0;
            while (issued < PHASE_ITEMS) begin
                n_pre = $urandom_range(2, 0);
                repeat (n_pre) begin
                    // Loads land either in rows that no run sweeps or inside the active block
                    if (big || $urandom_range(3) == 0) begin
                        row = IDX_W'($urandom_range(GUARD_V - 1, SMALL_V));
                        col = IDX_W'($urandom_range(63));
                    end else begin
                        row = IDX_W'($urandom_range(n_eff - 1));
                        col = IDX_W'($urandom_range(n_eff - 1));
                    end
                    push_beat(make_load(row, col, rand_weight(), $urandom_range(3) == 0),
                              1'b1);
                    issued++;
                end
                if (big)
                    src = IDX_W'(GUARD_V);
                else
                    src = ($urandom_range(7) == 0) ? IDX_W'($urandom_range(63))
                                                   : IDX_W'($urandom_range(n_eff - 1));
                push_beat(make_run(src), 1'b1);
                issued++;
                if ($urandom_range(9) == 0)
                    drain_results();
            end
        end

        drain_results();
        $display("Covered %0d loads, %0d runs (%0d with source out of range), %0d results",
                 n_loads, n_runs, n_ignored, n_checked);
        $display("over %0d vertex count writes, clamped values and all idle patterns.", n_cfg);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
